/* hdl/tsd_pkg.sv */
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the TGA stream decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int unsigned PADDR_W = 3;

	localparam logic [0:0] REG_RLE_TYPE_CODE = 1'b0;

	localparam logic [7:0] RLE_TYPE_CODE_RST = 8'd10;

	localparam logic [8:0] HDR_ID_LENGTH  = 9'd0;
	localparam logic [8:0] HDR_IMAGE_TYPE = 9'd2;
	localparam logic [8:0] HDR_WIDTH_LO   = 9'd12;
	localparam logic [8:0] HDR_WIDTH_HI   = 9'd13;
	localparam logic [8:0] HDR_HEIGHT_LO  = 9'd14;
	localparam logic [8:0] HDR_HEIGHT_HI  = 9'd15;
	localparam logic [8:0] HDR_DEPTH      = 9'd16;
	localparam logic [8:0] HDR_DESCRIPTOR = 9'd17;

	localparam logic [7:0] DEPTH_16 = 8'd16;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	localparam logic [2:0] CH_RGB  = 3'd3;
	localparam logic [2:0] CH_RGBA = 3'd4;

	localparam logic STATUS_PIXEL = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP_ID,
		PH_RAW,
		PH_RLE_HEAD,
		PH_RLE_COLOR,
		PH_DONE
	} tsd_phase_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  run_length;
		logic        last_pixel;
		logic [2:0]  channel_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        status;
	} tsd_result_t;

endpackage

/* hdl/tsd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tsd_cfg_regs
// APB register file holding the image type code that selects RLE decoding.
// ----------------------------------------------------------------------------
module tsd_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tsd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [7:0]                 rle_type_code
);

	logic       sel_rle_type;
	logic [7:0] rle_type_code_q;

	assign pready        = 1'b1;
	assign sel_rle_type  = (paddr[tsd_pkg::PADDR_W-1] == tsd_pkg::REG_RLE_TYPE_CODE);
	assign rle_type_code = rle_type_code_q;
	assign prdata        = sel_rle_type ? {24'd0, rle_type_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_type_code_q <= tsd_pkg::RLE_TYPE_CODE_RST;
		end else if (psel && penable && pwrite && sel_rle_type) begin
			rle_type_code_q <= pwdata[7:0];
		end
	end

endmodule

/* hdl/tsd_core.sv */
// ----------------------------------------------------------------------------
// tsd_core
// Header parser and pixel decoder: parser state registers and the
// single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module tsd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic [7:0]           rle_type_code,
	output logic                 emit,
	output tsd_pkg::tsd_result_t result
);

	tsd_pkg::tsd_phase_t phase_q, phase_d;
	logic [8:0]  byte_counter_q, byte_counter_d;
	logic [7:0]  id_length_q, id_length_d;
	logic [7:0]  image_type_q, image_type_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  pixel_depth_q, pixel_depth_d;
	logic [31:0] pixels_left_q, pixels_left_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic        packet_is_run_q, packet_is_run_d;
	logic [31:0] color_bytes_q, color_bytes_d;

	tsd_pkg::tsd_phase_t ph;
	logic [8:0]  bc;
	logic [31:0] pl;
	logic [7:0]  pkl;
	logic        is_run;
	logic [31:0] cb;
	logic [2:0]  nb;
	logic [31:0] cb_acc;
	logic [8:0]  bc_inc;
	logic        pixel_done;
	logic [31:0] area;
	logic        area_zero;
	logic        is_rle;
	logic        depth_ok;
	logic [7:0]  run;
	logic [31:0] pl_after;
	logic [7:0]  count;
	logic [7:0]  pix_r, pix_g, pix_b, pix_a;
	logic [2:0]  pix_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tsd_pkg::PH_HEADER;
			byte_counter_q  <= '0;
			id_length_q     <= '0;
			image_type_q    <= '0;
			width_q         <= '0;
			height_q        <= '0;
			pixel_depth_q   <= '0;
			pixels_left_q   <= '0;
			packet_left_q   <= '0;
			packet_is_run_q <= 1'b0;
			color_bytes_q   <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			byte_counter_q  <= byte_counter_d;
			id_length_q     <= id_length_d;
			image_type_q    <= image_type_d;
			width_q         <= width_d;
			height_q        <= height_d;
			pixel_depth_q   <= pixel_depth_d;
			pixels_left_q   <= pixels_left_d;
			packet_left_q   <= packet_left_d;
			packet_is_run_q <= packet_is_run_d;
			color_bytes_q   <= color_bytes_d;
		end
	end

	always_comb begin
		ph     = first_byte ? tsd_pkg::PH_HEADER : phase_q;
		bc     = first_byte ? 9'd0 : byte_counter_q;
		pl     = first_byte ? 32'd0 : pixels_left_q;
		pkl    = first_byte ? 8'd0 : packet_left_q;
		is_run = first_byte ? 1'b0 : packet_is_run_q;
		cb     = first_byte ? 32'd0 : color_bytes_q;

		if (pixel_depth_q == tsd_pkg::DEPTH_32) begin
			nb = 3'd4;
		end else if (pixel_depth_q == tsd_pkg::DEPTH_16) begin
			nb = 3'd2;
		end else begin
			nb = 3'd3;
		end

		case (bc[1:0])
			2'd0:    cb_acc = cb | {24'd0, data_byte};
			2'd1:    cb_acc = cb | {16'd0, data_byte, 8'd0};
			2'd2:    cb_acc = cb | {8'd0, data_byte, 16'd0};
			default: cb_acc = cb | {data_byte, 24'd0};
		endcase
		bc_inc     = bc + 9'd1;
		pixel_done = (bc_inc >= {6'd0, nb});

		if (pixel_depth_q == tsd_pkg::DEPTH_16) begin
			pix_b  = {cb_acc[4:0], 3'b000};
			pix_g  = {cb_acc[9:5], 3'b000};
			pix_r  = {cb_acc[14:10], 3'b000};
			pix_a  = 8'd0;
			pix_ch = tsd_pkg::CH_RGB;
		end else begin
			pix_b  = cb_acc[7:0];
			pix_g  = cb_acc[15:8];
			pix_r  = cb_acc[23:16];
			pix_a  = (pixel_depth_q == tsd_pkg::DEPTH_32) ? cb_acc[31:24] : 8'd0;
			pix_ch = (pixel_depth_q == tsd_pkg::DEPTH_32) ? tsd_pkg::CH_RGBA : tsd_pkg::CH_RGB;
		end

		run      = (ph == tsd_pkg::PH_RLE_COLOR && is_run) ? pkl : 8'd1;
		pl_after = pl - {24'd0, run};

		area      = {16'd0, width_q} * {16'd0, height_q};
		area_zero = (width_q == 16'd0) || (height_q == 16'd0);
		is_rle    = (image_type_q == rle_type_code);
		if (is_rle) begin
			depth_ok = (data_byte == tsd_pkg::DEPTH_24) || (data_byte == tsd_pkg::DEPTH_32);
		end else begin
			depth_ok = (data_byte == tsd_pkg::DEPTH_16) || (data_byte == tsd_pkg::DEPTH_24) ||
				(data_byte == tsd_pkg::DEPTH_32);
		end

		count = {1'b0, data_byte[6:0]} + 8'd1;
		if ({24'd0, count} > pl) begin
			count = pl[7:0];
		end

		phase_d         = ph;
		byte_counter_d  = bc;
		id_length_d     = id_length_q;
		image_type_d    = image_type_q;
		width_d         = width_q;
		height_d        = height_q;
		pixel_depth_d   = pixel_depth_q;
		pixels_left_d   = pl;
		packet_left_d   = pkl;
		packet_is_run_d = is_run;
		color_bytes_d   = cb;

		emit                 = 1'b0;
		result.red           = pix_r;
		result.green         = pix_g;
		result.blue          = pix_b;
		result.alpha         = pix_a;
		result.run_length    = run;
		result.last_pixel    = (pl_after == 32'd0);
		result.channel_count = pix_ch;
		result.image_width   = width_q;
		result.image_height  = height_q;
		result.status        = tsd_pkg::STATUS_PIXEL;

		case (ph)
			tsd_pkg::PH_HEADER: begin
				byte_counter_d = bc_inc;
				if (bc == tsd_pkg::HDR_ID_LENGTH) begin
					id_length_d = data_byte;
				end else if (bc == tsd_pkg::HDR_IMAGE_TYPE) begin
					image_type_d = data_byte;
				end else if (bc == tsd_pkg::HDR_WIDTH_LO) begin
					width_d = {width_q[15:8], data_byte};
				end else if (bc == tsd_pkg::HDR_WIDTH_HI) begin
					width_d = {data_byte, width_q[7:0]};
				end else if (bc == tsd_pkg::HDR_HEIGHT_LO) begin
					height_d = {height_q[15:8], data_byte};
				end else if (bc == tsd_pkg::HDR_HEIGHT_HI) begin
					height_d = {data_byte, height_q[7:0]};
				end else if (bc == tsd_pkg::HDR_DEPTH) begin
					pixel_depth_d = data_byte;
					if (!depth_ok) begin
						phase_d              = tsd_pkg::PH_DONE;
						byte_counter_d       = 9'd0;
						emit                 = 1'b1;
						result.red           = 8'd0;
						result.green         = 8'd0;
						result.blue          = 8'd0;
						result.alpha         = 8'd0;
						result.run_length    = 8'd0;
						result.last_pixel    = 1'b0;
						result.channel_count = 3'd0;
						result.status        = tsd_pkg::STATUS_ERROR;
					end
				end else if (bc >= tsd_pkg::HDR_DESCRIPTOR) begin
					byte_counter_d = 9'd0;
					if (id_length_q != 8'd0) begin
						phase_d = tsd_pkg::PH_SKIP_ID;
					end else begin
						pixels_left_d   = area;
						color_bytes_d   = 32'd0;
						packet_left_d   = 8'd0;
						packet_is_run_d = 1'b0;
						if (area_zero) begin
							phase_d = tsd_pkg::PH_DONE;
						end else if (is_rle) begin
							phase_d = tsd_pkg::PH_RLE_HEAD;
						end else begin
							phase_d = tsd_pkg::PH_RAW;
						end
					end
				end
			end
			tsd_pkg::PH_SKIP_ID: begin
				byte_counter_d = bc_inc;
				if (bc_inc >= {1'b0, id_length_q}) begin
					byte_counter_d  = 9'd0;
					pixels_left_d   = area;
					color_bytes_d   = 32'd0;
					packet_left_d   = 8'd0;
					packet_is_run_d = 1'b0;
					if (area_zero) begin
						phase_d = tsd_pkg::PH_DONE;
					end else if (is_rle) begin
						phase_d = tsd_pkg::PH_RLE_HEAD;
					end else begin
						phase_d = tsd_pkg::PH_RAW;
					end
				end
			end
			tsd_pkg::PH_RAW: begin
				color_bytes_d  = cb_acc;
				byte_counter_d = bc_inc;
				if (pixel_done) begin
					emit           = 1'b1;
					byte_counter_d = 9'd0;
					color_bytes_d  = 32'd0;
					pixels_left_d  = pl_after;
					if (pl_after == 32'd0) begin
						phase_d = tsd_pkg::PH_DONE;
					end
				end
			end
			tsd_pkg::PH_RLE_HEAD: begin
				packet_is_run_d = data_byte[7];
				packet_left_d   = count;
				byte_counter_d  = 9'd0;
				color_bytes_d   = 32'd0;
				phase_d = (count == 8'd0) ? tsd_pkg::PH_DONE : tsd_pkg::PH_RLE_COLOR;
			end
			tsd_pkg::PH_RLE_COLOR: begin
				color_bytes_d  = cb_acc;
				byte_counter_d = bc_inc;
				if (pixel_done) begin
					emit           = 1'b1;
					byte_counter_d = 9'd0;
					color_bytes_d  = 32'd0;
					pixels_left_d  = pl_after;
					packet_left_d  = pkl - run;
					if (pl_after == 32'd0) begin
						packet_left_d = 8'd0;
						phase_d       = tsd_pkg::PH_DONE;
					end else if (pkl == run) begin
						phase_d = tsd_pkg::PH_RLE_HEAD;
					end
				end
			end
			default: begin
				phase_d = ph;
			end
		endcase
	end

endmodule

/* hdl/tga_stream_decoder.sv */
// ----------------------------------------------------------------------------
// tga_stream_decoder
// TGA byte-stream decoder: header parse, uncompressed and RLE pixel decode.
//
//   Port group   Direction  Protocol       Payload
//   cfg (APB)    in/out     psel/penable   rle_type_code at address 0
//   in           in         valid/ready    data_byte, first_byte
//   out          out        valid/ready    pixel color, run, size, status
//
// Each byte passes through the input register and, when it completes a pixel
// or an error, the result register, so a transaction can be accepted every
// cycle while the output is not stalled.
// A stalled output holds the result register and the input register; the
// input stays ready while the input register is empty.
// Reset clears the parser to the start of a header and the type code to 10.
// ----------------------------------------------------------------------------
module tga_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        first_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic [7:0]                  alpha,
	output logic [7:0]                  run_length,
	output logic                        last_pixel,
	output logic [2:0]                  channel_count,
	output logic [15:0]                 image_width,
	output logic [15:0]                 image_height,
	output logic                        status
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 first_s1;
	logic                 valid_s2;
	tsd_pkg::tsd_result_t result_s2;
	tsd_pkg::tsd_result_t core_result;
	logic                 core_emit;
	logic [7:0]           rle_type_code;
	logic                 advance;
	logic                 step;
	logic                 in_fire;

	tsd_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.rle_type_code (rle_type_code)
	);

	tsd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_s1),
		.first_byte    (first_s1),
		.rle_type_code (rle_type_code),
		.emit          (core_emit),
		.result        (core_result)
	);

	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && core_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_emit) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid     = valid_s2;
	assign red           = result_s2.red;
	assign green         = result_s2.green;
	assign blue          = result_s2.blue;
	assign alpha         = result_s2.alpha;
	assign run_length    = result_s2.run_length;
	assign last_pixel    = result_s2.last_pixel;
	assign channel_count = result_s2.channel_count;
	assign image_width   = result_s2.image_width;
	assign image_height  = result_s2.image_height;
	assign status        = result_s2.status;

endmodule

/* tb/sv/tsd_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder checker
// Tracks the decoder's parse state byte by byte, predicts every pixel and
// format error result, and compares the results that come back in order.
// ----------------------------------------------------------------------------
package tsd_tb_pkg;

	import tsd_pkg::*;

	class tga_decode_checker;
		logic [7:0]  rle_code;
		tsd_phase_t  phase;
		logic [8:0]  byte_pos;
		logic [7:0]  id_len;
		logic [7:0]  img_type;
		logic [15:0] wid;
		logic [15:0] hgt;
		logic [7:0]  depth;
		logic [31:0] pix_left;
		logic [7:0]  pkt_left;
		logic        pkt_run;
		logic [31:0] color;

		tsd_result_t pending_pixels[$];

		int n_bytes;
		int n_pixels;
		int n_runs;
		int n_errors;
		int n_bad;

		function new();
			rle_code = RLE_TYPE_CODE_RST;
			phase = PH_HEADER;
			byte_pos = '0;
			id_len = '0;
			img_type = '0;
			wid = '0;
			hgt = '0;
			depth = '0;
			pix_left = '0;
			pkt_left = '0;
			pkt_run = 1'b0;
			color = '0;
			n_bytes = 0;
			n_pixels = 0;
			n_runs = 0;
			n_errors = 0;
			n_bad = 0;
		endfunction

		function int unsigned pixel_bytes();
			if (depth == DEPTH_32)
				return 4;
			if (depth == DEPTH_16)
				return 2;
			return 3;
		endfunction

		function void start_data();
			pix_left = 32'(wid) * 32'(hgt);
			byte_pos = '0;
			color = '0;
			pkt_left = '0;
			pkt_run = 1'b0;
			if (pix_left == 0)
				phase = PH_DONE;
			else if (img_type == rle_code)
				phase = PH_RLE_HEAD;
			else
				phase = PH_RAW;
		endfunction

		function void push_color(logic [7:0] run);
			tsd_result_t r;
			r = '0;
			r.channel_count = CH_RGB;
			if (depth == DEPTH_16) begin
				r.blue = {color[4:0], 3'b000};
				r.green = {color[9:5], 3'b000};
				r.red = {color[14:10], 3'b000};
			end else begin
				r.blue = color[7:0];
				r.green = color[15:8];
				r.red = color[23:16];
				if (depth == DEPTH_32) begin
					r.alpha = color[31:24];
					r.channel_count = CH_RGBA;
				end
			end
			pix_left = pix_left - 32'(run);
			r.run_length = run;
			r.last_pixel = (pix_left == 0);
			r.image_width = wid;
			r.image_height = hgt;
			r.status = STATUS_PIXEL;
			pending_pixels.push_back(r);
			byte_pos = '0;
			color = '0;
		endfunction

		function void take_byte(logic [7:0] d, logic first);
			logic        ok;
			logic [8:0]  cnt;
			logic [7:0]  run;
			tsd_result_t r;
			n_bytes++;
			if (first) begin
				phase = PH_HEADER;
				byte_pos = '0;
				pix_left = '0;
				pkt_left = '0;
				pkt_run = 1'b0;
				color = '0;
			end
			case (phase)
				PH_HEADER: begin
					if (byte_pos >= HDR_DESCRIPTOR) begin
						byte_pos = '0;
						if (id_len != 0)
							phase = PH_SKIP_ID;
						else
							start_data();
					end else begin
						ok = 1'b1;
						case (byte_pos)
							HDR_ID_LENGTH: id_len = d;
							HDR_IMAGE_TYPE: img_type = d;
							HDR_WIDTH_LO: wid[7:0] = d;
							HDR_WIDTH_HI: wid[15:8] = d;
							HDR_HEIGHT_LO: hgt[7:0] = d;
							HDR_HEIGHT_HI: hgt[15:8] = d;
							HDR_DEPTH: begin
								depth = d;
								if (img_type == rle_code)
									ok = (d == DEPTH_24) || (d == DEPTH_32);
								else
									ok = (d == DEPTH_16) || (d == DEPTH_24) || (d == DEPTH_32);
							end
							default: ;
						endcase
						if (!ok) begin
							phase = PH_DONE;
							byte_pos = '0;
							r = '0;
							r.image_width = wid;
							r.image_height = hgt;
							r.status = STATUS_ERROR;
							pending_pixels.push_back(r);
						end else begin
							byte_pos = byte_pos + 1'b1;
						end
					end
				end
				PH_SKIP_ID: begin
					byte_pos = byte_pos + 1'b1;
					if (byte_pos >= 9'(id_len))
						start_data();
				end
				PH_RAW: begin
					color = color | (32'(d) << (8 * byte_pos[1:0]));
					byte_pos = byte_pos + 1'b1;
					if (byte_pos >= pixel_bytes()) begin
						push_color(8'd1);
						if (pix_left == 0)
							phase = PH_DONE;
					end
				end
				PH_RLE_HEAD: begin
					if (d < 8'd128) begin
						cnt = 9'(d) + 9'd1;
						pkt_run = 1'b0;
					end else begin
						cnt = 9'(d) - 9'd127;
						pkt_run = 1'b1;
					end
					if (32'(cnt) > pix_left)
						cnt = 9'(pix_left);
					pkt_left = cnt[7:0];
					byte_pos = '0;
					color = '0;
					phase = (cnt == 0) ? PH_DONE : PH_RLE_COLOR;
				end
				PH_RLE_COLOR: begin
					color = color | (32'(d) << (8 * byte_pos[1:0]));
					byte_pos = byte_pos + 1'b1;
					if (byte_pos >= pixel_bytes()) begin
						run = pkt_run ? pkt_left : 8'd1;
						push_color(run);
						pkt_left = pkt_left - run;
						if (pix_left == 0) begin
							pkt_left = '0;
							phase = PH_DONE;
						end else if (pkt_left == 0) begin
							phase = PH_RLE_HEAD;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function string show(tsd_result_t r);
			return $sformatf("rgba=%h/%h/%h/%h run=%0d last=%0d ch=%0d size=%0dx%0d status=%0d",
				r.red, r.green, r.blue, r.alpha, r.run_length, r.last_pixel,
				r.channel_count, r.image_width, r.image_height, r.status);
		endfunction

		function void note_bad(string msg);
			n_bad++;
			if (n_bad <= 10)
				$display("[%0t] ERROR: %s", $time, msg);
		endfunction

		function void check_pixel(tsd_result_t got);
			tsd_result_t want;
			string       diffs;
			if (got.status == STATUS_ERROR)
				n_errors++;
			else
				n_pixels++;
			if (got.run_length > 1)
				n_runs++;
			if (pending_pixels.size() == 0) begin
				note_bad({"result with nothing expected: ", show(got)});
				return;
			end
			want = pending_pixels.pop_front();
			diffs = "";
			if (got.red !== want.red) diffs = {diffs, " red"};
			if (got.green !== want.green) diffs = {diffs, " green"};
			if (got.blue !== want.blue) diffs = {diffs, " blue"};
			if (got.alpha !== want.alpha) diffs = {diffs, " alpha"};
			if (got.run_length !== want.run_length) diffs = {diffs, " run_length"};
			if (got.last_pixel !== want.last_pixel) diffs = {diffs, " last_pixel"};
			if (got.channel_count !== want.channel_count) diffs = {diffs, " channel_count"};
			if (got.image_width !== want.image_width) diffs = {diffs, " image_width"};
			if (got.image_height !== want.image_height) diffs = {diffs, " image_height"};
			if (got.status !== want.status) diffs = {diffs, " status"};
			if (diffs != "")
				note_bad({"mismatch in", diffs, "\n  expected ", show(want), "\n  actual   ",
					show(got)});
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams TGA files through the decoder under random flow control on both
// sides and checks every result against a byte-level prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import tsd_pkg::*;
	import tsd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 100;
	localparam logic [PADDR_W-1:0] RLE_CODE_ADDR = PADDR_W'(4 * REG_RLE_TYPE_CODE);

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               first_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	logic [7:0]         run_length;
	logic               last_pixel;
	logic [2:0]         channel_count;
	logic [15:0]        image_width;
	logic [15:0]        image_height;
	logic               status;

	tga_decode_checker tga_check;
	logic [7:0]        file_bytes[$];
	logic [7:0]        cur_code;
	int                in_gap_pct;
	int                out_stall_pct;
	bit                hold_out;
	int                cycles;

	tga_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.run_length(run_length),
		.last_pixel(last_pixel),
		.channel_count(channel_count),
		.image_width(image_width),
		.image_height(image_height),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : transaction_monitor
		tsd_result_t got;
		if (in_valid && in_ready)
			tga_check.take_byte(data_byte, first_byte);
		if (out_valid && out_ready) begin
			got = {red, green, blue, alpha, run_length, last_pixel, channel_count,
				image_width, image_height, status};
			tga_check.check_pixel(got);
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				hold_out = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			data_byte <= file_bytes[i];
			first_byte <= (i == 0);
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
		end
		file_bytes.delete();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tga_check.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rle_code(input logic [7:0] code);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RLE_CODE_ADDR;
		pwdata <= {24'd0, code};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tga_check.rle_code = code;
		cur_code = code;
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(8'($urandom));
	endtask

	task automatic make_header(input logic [7:0] idl, input logic [7:0] typ,
		input logic [15:0] w, input logic [15:0] h, input logic [7:0] dep);
		file_bytes.push_back(idl);
		push_random(1);
		file_bytes.push_back(typ);
		push_random(9);
		file_bytes.push_back(w[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(dep);
		push_random(1);
	endtask

	task automatic make_random_file();
		int          r;
		int          idl;
		int          bpp;
		int          cnt;
		int          used;
		int          packets;
		longint      remaining;
		logic [7:0]  typ;
		logic [7:0]  dep;
		logic [15:0] w;
		logic [15:0] h;
		bit          rle;
		bit          ok;
		r = $urandom_range(0, 99);
		idl = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 4) : (r < 98) ? $urandom_range(5, 20) : 255;
		r = $urandom_range(0, 99);
		typ = (r < 45) ? cur_code : (r < 85) ? 8'd2 : (r < 92) ? 8'd3 : 8'($urandom);
		rle = (typ == cur_code);
		r = $urandom_range(0, 99);
		if (r < 85) begin
			case ($urandom_range(0, 2))
				0: dep = DEPTH_16;
				1: dep = DEPTH_24;
				default: dep = DEPTH_32;
			endcase
		end else begin
			dep = 8'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 4));
			h = (w == 0) ? 16'($urandom_range(0, 4)) : 16'd0;
		end else if (r < 14) begin
			w = $urandom_range(0, 1) ? 16'hffff : 16'($urandom);
			h = $urandom_range(0, 1) ? 16'hffff : 16'($urandom);
		end else if (r < 26) begin
			w = 16'($urandom_range(100, 255));
			h = 16'd1;
		end else begin
			w = 16'($urandom_range(1, 6));
			h = 16'($urandom_range(1, 4));
		end
		make_header(8'(idl), typ, w, h, dep);
		if ($urandom_range(0, 99) < 4) begin
			cnt = $urandom_range(1, 17);
			while (file_bytes.size() > cnt)
				void'(file_bytes.pop_back());
			return;
		end
		push_random(idl);
		if (rle)
			ok = (dep == DEPTH_24) || (dep == DEPTH_32);
		else
			ok = (dep == DEPTH_16) || (dep == DEPTH_24) || (dep == DEPTH_32);
		remaining = longint'(w) * longint'(h);
		if (!ok || remaining == 0) begin
			if ($urandom_range(0, 99) < 30)
				push_random($urandom_range(1, 3));
			return;
		end
		bpp = (dep == DEPTH_32) ? 4 : (dep == DEPTH_16) ? 2 : 3;
		if (!rle) begin
			used = (remaining > 40) ? 40 : int'(remaining);
			push_random(used * bpp);
			remaining -= used;
		end else begin
			packets = 0;
			while (remaining > 0 && packets < 16) begin
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 1)) begin
					if (r < 15)
						cnt = 128;
					else
						cnt = $urandom_range(1, (remaining > 128) ? 128 : int'(remaining));
					file_bytes.push_back(8'(127 + cnt));
					push_random(bpp);
				end else begin
					if (r < 10 && remaining <= 8)
						cnt = $urandom_range(1, 128);
					else
						cnt = $urandom_range(1, (remaining > 4) ? 4 : int'(remaining));
					file_bytes.push_back(8'(cnt - 1));
					push_random(((cnt > remaining) ? int'(remaining) : cnt) * bpp);
				end
				remaining -= (cnt > remaining) ? remaining : cnt;
				packets++;
			end
		end
		if (remaining == 0 && $urandom_range(0, 99) < 15)
			push_random($urandom_range(1, 3));
	endtask

	task automatic run_directed();
		make_header(8'd0, 8'd2, 16'd1, 16'd1, DEPTH_24);
		file_bytes.push_back(8'hff);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'h80);
		file_bytes.push_back(8'h5a);
		send_file();
		make_header(8'd1, RLE_TYPE_CODE_RST, 16'd2, 16'd1, DEPTH_32);
		file_bytes.push_back(8'hc3);
		file_bytes.push_back(8'hff);
		file_bytes.push_back(8'h01);
		file_bytes.push_back(8'h02);
		file_bytes.push_back(8'h03);
		file_bytes.push_back(8'hfe);
		send_file();
		make_header(8'd0, 8'd2, 16'd1, 16'd1, DEPTH_16);
		file_bytes.push_back(8'hff);
		file_bytes.push_back(8'hff);
		send_file();
		make_header(8'd0, RLE_TYPE_CODE_RST, 16'd4, 16'd4, DEPTH_16);
		file_bytes.push_back(8'h00);
		send_file();
		make_header(8'd0, 8'd2, 16'd0, 16'd3, DEPTH_24);
		file_bytes.push_back(8'h01);
		send_file();
		make_header(8'd0, 8'd3, 16'hffff, 16'h0001, 8'd8);
		send_file();
	endtask

	initial begin
		int start_bytes;
		bit held;
		tga_check = new();
		cur_code = RLE_TYPE_CODE_RST;
		in_gap_pct = 0;
		out_stall_pct = 0;
		hold_out = 1'b0;
		cycles = 0;
		held = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		first_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					in_gap_pct = 25;
					out_stall_pct = 25;
				end
				1: begin
					write_rle_code(8'd255);
					in_gap_pct = 0;
					out_stall_pct = 40;
				end
				2: begin
					write_rle_code(8'd0);
					in_gap_pct = 50;
					out_stall_pct = 10;
				end
				3: begin
					write_rle_code(8'($urandom_range(1, 254)));
					in_gap_pct = 10;
					out_stall_pct = 0;
				end
				default: begin
					write_rle_code(RLE_TYPE_CODE_RST);
					in_gap_pct = 0;
					out_stall_pct = 0;
				end
			endcase
			if (ph == 0)
				run_directed();
			start_bytes = tga_check.n_bytes;
			while (tga_check.n_bytes - start_bytes < PHASE_BYTES) begin
				if (ph == 1 && !held && tga_check.n_bytes - start_bytes > 40) begin
					hold_out = 1'b1;
					held = 1'b1;
				end
				make_random_file();
				send_file();
			end
			drain();
		end

		$display("Run covered %0d input bytes, %0d pixel results (%0d runs longer than one)",
			tga_check.n_bytes, tga_check.n_pixels, tga_check.n_runs);
		$display("and %0d format errors across five type code phases; %0d mismatches.",
			tga_check.n_errors, tga_check.n_bad);
		if (tga_check.n_bad == 0 && tga_check.pending_pixels.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/tsd_pkg.sv
hdl/tsd_cfg_regs.sv
hdl/tsd_core.sv
hdl/tga_stream_decoder.sv
tb/sv/tsd_tb_pkg.sv
tb/sv/tb_top.sv
